FILE: hw/rtl/bsa_pkg.sv
// bsa_pkg: shared types and constants of the bilinear splat accumulator
// depends on nothing; used by bsa_front, bsa_back, the top level and the testbench by scoped names
`default_nettype none

package bsa_pkg;

    // fixed field widths
    localparam int KIND_W      = 2;
    localparam int POS_W       = 20;
    localparam int VALUE_W     = 24;
    localparam int INDEX_W     = 16;
    localparam int SUM_W       = 32;
    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CORNERS     = 4;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // reset value of both size registers
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // saturation ceiling of a pixel sum
    localparam logic [SUM_W-1:0] SUM_MAX = 32'hFFFF_FFFF;

    // item kinds as coded on the kind port
    typedef enum logic [KIND_W-1:0] {
        OP_SPLAT    = 2'd0,
        OP_READ     = 2'd1,
        OP_READ_CLR = 2'd2
    } op_t;

    // classification of one queued command
    typedef struct packed {
        op_t                op;
        logic [CORNERS-1:0] on_image;
        logic               rd_valid;
    } cmd_ctl_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SPLAT,
        BK_READ
    } bk_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bsa_ram.sv
// bsa_ram: generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bsa_fifo.sv
// bsa_fifo: small register queue with push/full and pop/empty sides
// depends on nothing
`default_nettype none

module bsa_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wdata,
    output logic                   full,
    input  wire logic              pop,
    output logic      [DATA_W-1:0] rdata,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage of queued words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bsa_front.sv
// bsa_front: accepts items, splits splat positions into corners and fractions,
// checks corners and read indexes against the image, forms pixel addresses
// depends on bsa_pkg
`default_nettype none

module bsa_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8,
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    push,
    output logic                                         full,
    input  wire logic [bsa_pkg::KIND_W-1:0]              kind,
    input  wire logic [bsa_pkg::POS_W-1:0]               pos_x,
    input  wire logic [bsa_pkg::POS_W-1:0]               pos_y,
    input  wire logic [bsa_pkg::VALUE_W-1:0]             splat_value,
    input  wire logic [bsa_pkg::INDEX_W-1:0]             pixel_index,
    input  wire logic [bsa_pkg::CFG_W-1:0]               eff_width,
    input  wire logic [bsa_pkg::CFG_W-1:0]               eff_height,
    input  wire logic                                    clearing,
    input  wire logic                                    cmd_full,
    output logic                                         cmd_push,
    output bsa_pkg::cmd_ctl_t                            cmd_ctl,
    output logic      [bsa_pkg::VALUE_W-1:0]             cmd_value,
    output logic      [FRAC_BITS-1:0]                    cmd_fx,
    output logic      [FRAC_BITS-1:0]                    cmd_fy,
    output logic      [bsa_pkg::CORNERS-1:0][ADDR_W-1:0] cmd_addr
);

    localparam int P_W   = bsa_pkg::POS_W + 1;
    localparam int CW    = P_W - FRAC_BITS + 1;
    localparam int ROW_W = 2 * bsa_pkg::CFG_W;
    localparam logic [P_W-1:0] HALF = P_W'(1) << (FRAC_BITS - 1);

    // position split on the input side
    logic [P_W-1:0] px, py;
    logic [CW-1:0]  cx0, cx1, cy0, cy1;
    logic           ix0, ix1, iy0, iy1;
    logic           accept, keep;

    assign px  = {pos_x[bsa_pkg::POS_W-1], pos_x} - HALF;
    assign py  = {pos_y[bsa_pkg::POS_W-1], pos_y} - HALF;
    assign cx0 = {px[P_W-1], px[P_W-1:FRAC_BITS]};
    assign cy0 = {py[P_W-1], py[P_W-1:FRAC_BITS]};
    assign cx1 = cx0 + CW'(1);
    assign cy1 = cy0 + CW'(1);
    assign ix0 = !cx0[CW-1] && (cx0 < CW'(eff_width));
    assign ix1 = !cx1[CW-1] && (cx1 < CW'(eff_width));
    assign iy0 = !cy0[CW-1] && (cy0 < CW'(eff_height));
    assign iy1 = !cy1[CW-1] && (cy1 < CW'(eff_height));

    // handshake: hold a classified item until the command queue takes it
    logic a_valid_reg, a_valid_next;

    assign full   = clearing || (a_valid_reg && cmd_full);
    assign accept = push && !full;

    // the unused kind code is accepted and dropped
    always_comb
    begin
        unique case (kind)
            bsa_pkg::OP_SPLAT:    keep = 1'b1;
            bsa_pkg::OP_READ:     keep = 1'b1;
            bsa_pkg::OP_READ_CLR: keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    assign a_valid_next = (a_valid_reg && cmd_full) || (accept && keep);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    // classified item register
    bsa_pkg::op_t                 op_a_reg;
    logic [bsa_pkg::CORNERS-1:0]  in_a_reg;
    logic [FRAC_BITS-1:0]         fx_a_reg, fy_a_reg;
    logic [bsa_pkg::CFG_W-1:0]    x0_a_reg, y1_a_reg;
    logic [bsa_pkg::VALUE_W-1:0]  value_a_reg;
    logic [bsa_pkg::INDEX_W-1:0]  index_a_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_a_reg    <= bsa_pkg::op_t'(kind);
            in_a_reg    <= {ix1 && iy1, ix0 && iy1, ix1 && iy0, ix0 && iy0};
            fx_a_reg    <= px[FRAC_BITS-1:0];
            fy_a_reg    <= py[FRAC_BITS-1:0];
            x0_a_reg    <= cx0[bsa_pkg::CFG_W-1:0];
            y1_a_reg    <= cy1[bsa_pkg::CFG_W-1:0];
            value_a_reg <= splat_value;
            index_a_reg <= pixel_index;
        end
    end

    // row base and corner addresses; one multiplier shared with the read bound
    logic                      is_splat;
    logic [bsa_pkg::CFG_W-1:0] x1_a;
    logic [ROW_W-1:0]          mul_a, row1, row0, col0, col1;
    logic [ROW_W-1:0]          a00, a10, a01, a11;
    logic                      rd_valid;

    // right column wraps at the register width so a left corner of -1 gives column 0
    assign x1_a     = x0_a_reg + bsa_pkg::CFG_W'(1);
    assign is_splat = (op_a_reg == bsa_pkg::OP_SPLAT);
    assign mul_a    = ROW_W'(is_splat ? y1_a_reg : eff_height);
    assign row1     = mul_a * ROW_W'(eff_width);
    assign row0     = row1 - ROW_W'(eff_width);
    assign col0     = ROW_W'(x0_a_reg);
    assign col1     = ROW_W'(x1_a);
    assign a00      = row0 + col0;
    assign a10      = row0 + col1;
    assign a01      = row1 + col0;
    assign a11      = row1 + col1;
    assign rd_valid = (ROW_W'(index_a_reg) < row1) && (32'(index_a_reg) < DEPTH);

    // command word toward the back end
    assign cmd_push          = a_valid_reg && !cmd_full;
    assign cmd_ctl.op        = op_a_reg;
    assign cmd_ctl.on_image  = in_a_reg;
    assign cmd_ctl.rd_valid  = rd_valid;
    assign cmd_value         = value_a_reg;
    assign cmd_fx            = fx_a_reg;
    assign cmd_fy            = fy_a_reg;
    assign cmd_addr[0]       = is_splat ? ADDR_W'(a00) : ADDR_W'(index_a_reg);
    assign cmd_addr[1]       = ADDR_W'(a10);
    assign cmd_addr[2]       = ADDR_W'(a01);
    assign cmd_addr[3]       = ADDR_W'(a11);

endmodule

`default_nettype wire

FILE: hw/rtl/bsa_back.sv
// bsa_back: sequencer that clears the pixel memory after reset and carries out
// splat read-modify-writes and pixel reads on it
// depends on bsa_pkg and bsa_ram
`default_nettype none

module bsa_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8,
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cmd_empty,
    output logic                                         cmd_pop,
    input  wire bsa_pkg::cmd_ctl_t                       cmd_ctl,
    input  wire logic [bsa_pkg::VALUE_W-1:0]             cmd_value,
    input  wire logic [FRAC_BITS-1:0]                    cmd_fx,
    input  wire logic [FRAC_BITS-1:0]                    cmd_fy,
    input  wire logic [bsa_pkg::CORNERS-1:0][ADDR_W-1:0] cmd_addr,
    input  wire logic                                    res_full,
    output logic                                         res_push,
    output logic      [bsa_pkg::SUM_W-1:0]               res_sum,
    output logic                                         res_valid,
    output logic                                         clearing
);

    localparam int ONE_W = FRAC_BITS + 1;
    localparam int WGT_W = 2 * FRAC_BITS + 2;
    localparam int PRD_W = bsa_pkg::VALUE_W + WGT_W;
    localparam int ADD_W = PRD_W - 2 * FRAC_BITS;
    localparam logic [ONE_W-1:0]  ONE        = ONE_W'(1) << FRAC_BITS;
    localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(DEPTH - 1);
    localparam logic [2:0]        SPLAT_LAST = 3'd5;
    localparam logic [2:0]        READ_LAST  = 3'd1;
    localparam logic [2:0]        WR_FIRST   = 3'd2;

    bsa_pkg::bk_state_t state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;

    // command registers
    bsa_pkg::cmd_ctl_t                      ctl_reg;
    logic [bsa_pkg::VALUE_W-1:0]            value_reg;
    logic [FRAC_BITS-1:0]                   fx_reg, fy_reg;
    logic [bsa_pkg::CORNERS-1:0][ADDR_W-1:0] addr_reg;

    // corner pipeline registers
    logic [WGT_W-1:0]  weight_reg;
    logic [ADD_W-1:0]  add_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              wr_in_reg;

    // memory port signals
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
    logic [bsa_pkg::SUM_W-1:0] mem_wdata, mem_rdata;

    // next state
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            bsa_pkg::BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next    = bsa_pkg::BK_IDLE;
                    clr_addr_next = '0;
                end
            end
            bsa_pkg::BK_IDLE:
            begin
                cnt_next = '0;
                if (!cmd_empty)
                begin
                    priority if (cmd_ctl.op == bsa_pkg::OP_SPLAT)
                    begin
                        state_next = bsa_pkg::BK_SPLAT;
                    end
                    else if (!res_full)
                    begin
                        state_next = bsa_pkg::BK_READ;
                    end
                    else
                    begin
                        state_next = bsa_pkg::BK_IDLE;
                    end
                end
            end
            bsa_pkg::BK_SPLAT:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == SPLAT_LAST)
                begin
                    state_next = bsa_pkg::BK_IDLE;
                    cnt_next   = '0;
                end
            end
            bsa_pkg::BK_READ:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == READ_LAST)
                begin
                    state_next = bsa_pkg::BK_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = bsa_pkg::BK_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bsa_pkg::BK_CLEAR;
            cnt_reg      <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // corner selects: weight stage on cnt, multiply and read stage one behind
    logic [2:0]        cnt_m1;
    logic [1:0]        wgt_corner, mul_corner;
    logic [ONE_W-1:0]  gx, gy, wa, wb;
    logic [PRD_W-1:0]  prod;
    logic [bsa_pkg::SUM_W:0] sum_wide;
    logic [bsa_pkg::SUM_W-1:0] sat_sum;

    assign cnt_m1     = cnt_reg - 3'd1;
    assign wgt_corner = cnt_reg[1:0];
    assign mul_corner = cnt_m1[1:0];
    assign gx         = ONE - ONE_W'(fx_reg);
    assign gy         = ONE - ONE_W'(fy_reg);
    assign wa         = wgt_corner[0] ? ONE_W'(fx_reg) : gx;
    assign wb         = wgt_corner[1] ? ONE_W'(fy_reg) : gy;
    assign prod       = PRD_W'(value_reg) * PRD_W'(weight_reg);

    // saturating accumulate
    assign sum_wide = {1'b0, mem_rdata} + (bsa_pkg::SUM_W + 1)'(add_reg);
    assign sat_sum  = sum_wide[bsa_pkg::SUM_W] ? bsa_pkg::SUM_MAX
                                               : sum_wide[bsa_pkg::SUM_W-1:0];

    // outputs of the sequencer
    always_comb
    begin
        cmd_pop   = 1'b0;
        res_push  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = sat_sum;
        mem_raddr = addr_reg[0];
        unique case (state_reg)
            bsa_pkg::BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            bsa_pkg::BK_IDLE:
            begin
                cmd_pop = !cmd_empty && ((cmd_ctl.op == bsa_pkg::OP_SPLAT) || !res_full);
            end
            bsa_pkg::BK_SPLAT:
            begin
                mem_raddr = addr_reg[mul_corner];
                mem_we    = (cnt_reg >= WR_FIRST) && wr_in_reg;
            end
            bsa_pkg::BK_READ:
            begin
                if (cnt_reg == READ_LAST)
                begin
                    res_push  = 1'b1;
                    mem_we    = (ctl_reg.op == bsa_pkg::OP_READ_CLR) && ctl_reg.rd_valid;
                    mem_waddr = addr_reg[0];
                    mem_wdata = '0;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    assign clearing  = (state_reg == bsa_pkg::BK_CLEAR);
    assign res_sum   = ctl_reg.rd_valid ? mem_rdata : '0;
    assign res_valid = ctl_reg.rd_valid;

    // command load and corner pipeline
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            ctl_reg   <= cmd_ctl;
            value_reg <= cmd_value;
            fx_reg    <= cmd_fx;
            fy_reg    <= cmd_fy;
            addr_reg  <= cmd_addr;
        end
        weight_reg  <= WGT_W'(wa) * WGT_W'(wb);
        add_reg     <= prod[PRD_W-1 -: ADD_W];
        wr_addr_reg <= addr_reg[mul_corner];
        wr_in_reg   <= ctl_reg.on_image[mul_corner];
    end

    // pixel memory
    bsa_ram #(
        .WIDTH (bsa_pkg::SUM_W),
        .DEPTH (DEPTH)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/bilinear_splat_accumulator.sv
// bilinear_splat_accumulator: top level, size registers, front end, command
// queue, back end and result queue
// depends on bsa_pkg, bsa_fifo, bsa_front, bsa_back
//
// channel  | handshake              | word
// ---------+------------------------+-----------------------------------------
// input    | push, full             | kind, pos_x, pos_y, splat_value, pixel_index
// result   | pop, empty             | pixel_sum, index_valid
// config   | cfg_we                 | cfg_index, cfg_data
//
// in the back end a splat is a pop, then four corner read-modify-writes on
// the pixel memory through a weight/multiply pipeline; a read is a pop, a
// memory read and a result push
// after reset the back end clears all MAX_WIDTH * MAX_HEIGHT words of the pixel
// memory (65536 at the defaults), one word per cycle; full stays high meanwhile
// a two-entry command queue separates front and back, and a two-entry result
// queue lets reads finish while the result side stalls
`default_nettype none

module bilinear_splat_accumulator #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [bsa_pkg::KIND_W-1:0]          kind,
    input  wire logic [bsa_pkg::POS_W-1:0]           pos_x,
    input  wire logic [bsa_pkg::POS_W-1:0]           pos_y,
    input  wire logic [bsa_pkg::VALUE_W-1:0]         splat_value,
    input  wire logic [bsa_pkg::INDEX_W-1:0]         pixel_index,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic      [bsa_pkg::SUM_W-1:0]           pixel_sum,
    output logic                                     index_valid,
    input  wire logic                                cfg_we,
    input  wire logic [bsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [bsa_pkg::CFG_W-1:0]           cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMD_W  = $bits(bsa_pkg::cmd_ctl_t) + bsa_pkg::VALUE_W
                            + 2 * FRAC_BITS + bsa_pkg::CORNERS * ADDR_W;
    localparam int RES_W  = bsa_pkg::SUM_W + 1;

    // size registers
    logic [bsa_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [bsa_pkg::CFG_W-1:0] eff_width, eff_height;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bsa_pkg::CFG_RESET;
            height_reg <= bsa_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsa_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bsa_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    // sizes above the store bounds are clamped
    assign eff_width  = (32'(width_reg) > MAX_WIDTH) ? bsa_pkg::CFG_W'(MAX_WIDTH)
                                                     : width_reg;
    assign eff_height = (32'(height_reg) > MAX_HEIGHT) ? bsa_pkg::CFG_W'(MAX_HEIGHT)
                                                       : height_reg;

    // front end
    logic                                     clearing;
    logic                                     cmd_push, cmd_full, cmd_pop, cmd_empty;
    bsa_pkg::cmd_ctl_t                        f_ctl, b_ctl;
    logic [bsa_pkg::VALUE_W-1:0]              f_value, b_value;
    logic [FRAC_BITS-1:0]                     f_fx, f_fy, b_fx, b_fy;
    logic [bsa_pkg::CORNERS-1:0][ADDR_W-1:0]  f_addr, b_addr;
    logic [CMD_W-1:0]                         cmd_wword, cmd_rword;

    bsa_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .splat_value (splat_value),
        .pixel_index (pixel_index),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .clearing    (clearing),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_ctl     (f_ctl),
        .cmd_value   (f_value),
        .cmd_fx      (f_fx),
        .cmd_fy      (f_fy),
        .cmd_addr    (f_addr)
    );

    // command queue between front and back
    assign cmd_wword = {f_ctl, f_value, f_fx, f_fy, f_addr};
    assign {b_ctl, b_value, b_fx, b_fy, b_addr} = cmd_rword;

    bsa_fifo #(
        .DATA_W (CMD_W),
        .DEPTH  (2)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wword),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rword),
        .empty (cmd_empty)
    );

    // back end
    logic                      res_push, res_full, res_valid;
    logic [bsa_pkg::SUM_W-1:0] res_sum;
    logic [RES_W-1:0]          res_rword;

    bsa_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_ctl   (b_ctl),
        .cmd_value (b_value),
        .cmd_fx    (b_fx),
        .cmd_fy    (b_fy),
        .cmd_addr  (b_addr),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_sum   (res_sum),
        .res_valid (res_valid),
        .clearing  (clearing)
    );

    // result queue
    bsa_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata ({res_valid, res_sum}),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rword),
        .empty (empty)
    );

    assign pixel_sum   = res_rword[bsa_pkg::SUM_W-1:0];
    assign index_valid = res_rword[bsa_pkg::SUM_W];

endmodule

`default_nettype wire

FILE: tb/bilinear_splat_accumulator_tb.sv
`timescale 1ns / 1ps
// bilinear_splat_accumulator_tb: self-checking regression of the bilinear splat accumulator
// mirrors the pixel store, drives splat and read words, checks every read word; needs bsa_pkg

module bilinear_splat_accumulator_tb;

    localparam int MAX_W         = 256;
    localparam int MAX_H         = 256;
    localparam int FRAC          = 8;
    localparam int ONE           = 1 << FRAC;
    localparam int STORE_WORDS   = MAX_W * MAX_H;
    localparam int MAX_GAP       = 11;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_WORDS   = 130;
    localparam int SAT_WORDS     = 300;

    // kind code the block drops, and register indexes it does not decode
    localparam logic [bsa_pkg::KIND_W-1:0]      KIND_IGNORED = 2'd3;
    localparam logic [bsa_pkg::CFG_INDEX_W-1:0] REG_SPARE_A  = 2'd2;
    localparam logic [bsa_pkg::CFG_INDEX_W-1:0] REG_SPARE_B  = 2'd3;

    typedef struct {
        logic [bsa_pkg::KIND_W-1:0]  kind;
        logic [bsa_pkg::POS_W-1:0]   pos_x;
        logic [bsa_pkg::POS_W-1:0]   pos_y;
        logic [bsa_pkg::VALUE_W-1:0] value;
        logic [bsa_pkg::INDEX_W-1:0] index;
    } splat_word_t;

    typedef struct {
        logic [bsa_pkg::SUM_W-1:0] sum;
        logic                      valid;
    } read_word_t;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            push        = 1'b0;
    logic                            full;
    logic [bsa_pkg::KIND_W-1:0]      kind        = '0;
    logic [bsa_pkg::POS_W-1:0]       pos_x       = '0;
    logic [bsa_pkg::POS_W-1:0]       pos_y       = '0;
    logic [bsa_pkg::VALUE_W-1:0]     splat_value = '0;
    logic [bsa_pkg::INDEX_W-1:0]     pixel_index = '0;
    logic                            empty;
    logic                            pop         = 1'b0;
    logic [bsa_pkg::SUM_W-1:0]       pixel_sum;
    logic                            index_valid;
    logic                            cfg_we      = 1'b0;
    logic [bsa_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [bsa_pkg::CFG_W-1:0]       cfg_data    = '0;

    // predictor state: pixel sums and size registers
    logic [bsa_pkg::SUM_W-1:0] pixel_mirror [0:STORE_WORDS-1];
    int                        image_width  = 256;
    int                        image_height = 256;
    read_word_t                expected_reads [$];

    int error_count  = 0;
    bit send_steady  = 1'b0;
    bit recv_steady  = 1'b0;
    int recv_wait    = 0;

    bilinear_splat_accumulator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .splat_value (splat_value),
        .pixel_index (pixel_index),
        .empty       (empty),
        .pop         (pop),
        .pixel_sum   (pixel_sum),
        .index_valid (index_valid),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("bilinear_splat_accumulator regression: fail");
        $finish;
    end

    function automatic int active_width();
        return (image_width > MAX_W) ? MAX_W : image_width;
    endfunction

    function automatic int active_height();
        return (image_height > MAX_H) ? MAX_H : image_height;
    endfunction

    // remove the half-pixel offset, then floor corner and fraction
    function automatic void split_axis(input logic [bsa_pkg::POS_W-1:0] raw,
                                       output int corner, output int frac);
        int p;
        p = int'($signed(raw)) - ONE / 2;
        frac = p & (ONE - 1);
        corner = (p - frac) / ONE;
    endfunction

    // saturating add of value * weight into one corner, skipped when off the image
    function automatic void add_to_pixel(input int cx, input int cy,
                                         input logic [bsa_pkg::VALUE_W-1:0] value,
                                         input longint weight);
        int     w;
        int     h;
        int     idx;
        longint addend;
        longint total;
        w = active_width();
        h = active_height();
        if (cx < 0 || cy < 0 || cx >= w || cy >= h)
            return;
        idx = cy * w + cx;
        addend = ({40'd0, value} * weight) >> (2 * FRAC);
        total = {32'd0, pixel_mirror[idx]} + addend;
        if (total > 64'h0000_0000_FFFF_FFFF)
            pixel_mirror[idx] = bsa_pkg::SUM_MAX;
        else
            pixel_mirror[idx] = total[bsa_pkg::SUM_W-1:0];
    endfunction

    // update the mirror for one accepted word and queue the read word it yields
    function automatic void predict_word(input splat_word_t word);
        int         x0;
        int         y0;
        int         fx;
        int         fy;
        int         gx;
        int         gy;
        int         limit;
        read_word_t entry;
        case (word.kind)
            bsa_pkg::OP_SPLAT:
            begin
                split_axis(word.pos_x, x0, fx);
                split_axis(word.pos_y, y0, fy);
                gx = ONE - fx;
                gy = ONE - fy;
                add_to_pixel(x0,     y0,     word.value, longint'(gx * gy));
                add_to_pixel(x0 + 1, y0,     word.value, longint'(fx * gy));
                add_to_pixel(x0,     y0 + 1, word.value, longint'(gx * fy));
                add_to_pixel(x0 + 1, y0 + 1, word.value, longint'(fx * fy));
            end
            bsa_pkg::OP_READ, bsa_pkg::OP_READ_CLR:
            begin
                limit = active_width() * active_height();
                if (int'(word.index) < limit)
                begin
                    entry.sum = pixel_mirror[word.index];
                    entry.valid = 1'b1;
                    if (word.kind == bsa_pkg::OP_READ_CLR)
                        pixel_mirror[word.index] = '0;
                end
                else
                begin
                    entry.sum = '0;
                    entry.valid = 1'b0;
                end
                expected_reads.insert(expected_reads.size(), entry);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic splat_word_t make_word(input logic [bsa_pkg::KIND_W-1:0] k,
                                              input int px, input int py,
                                              input int value, input int index);
        splat_word_t word;
        word.kind = k;
        word.pos_x = px[bsa_pkg::POS_W-1:0];
        word.pos_y = py[bsa_pkg::POS_W-1:0];
        word.value = value[bsa_pkg::VALUE_W-1:0];
        word.index = index[bsa_pkg::INDEX_W-1:0];
        return word;
    endfunction

    // position (in raw fixed point) of the centre of pixel c
    function automatic int pixel_centre(input int c);
        return c * ONE + ONE / 2;
    endfunction

    // mostly well-formed splats and targeted reads, some noise
    function automatic splat_word_t random_word();
        splat_word_t word;
        int          w;
        int          h;
        int          pick;
        int          r;
        int          tmp;
        w = active_width();
        h = active_height();
        r = $urandom;
        word.kind = bsa_pkg::OP_SPLAT;
        word.pos_x = r[bsa_pkg::POS_W-1:0];
        r = $urandom;
        word.pos_y = r[bsa_pkg::POS_W-1:0];
        r = $urandom;
        word.value = r[bsa_pkg::VALUE_W-1:0];
        r = $urandom;
        word.index = r[bsa_pkg::INDEX_W-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // splat on the image or one pixel around it
            tmp = int'($urandom_range(0, (w + 2) * ONE)) - ONE;
            word.pos_x = tmp[bsa_pkg::POS_W-1:0];
            tmp = int'($urandom_range(0, (h + 2) * ONE)) - ONE;
            word.pos_y = tmp[bsa_pkg::POS_W-1:0];
            case ($urandom_range(0, 3))
                0: word.value = '1;
                1:
                begin
                    tmp = $urandom_range(0, 255);
                    word.value = tmp[bsa_pkg::VALUE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (pick < 85)
        begin
            // read of a pixel inside the image
            word.kind = $urandom_range(0, 1) ? bsa_pkg::OP_READ_CLR : bsa_pkg::OP_READ;
            if (w > 0 && h > 0)
            begin
                tmp = int'($urandom_range(0, h - 1)) * w + int'($urandom_range(0, w - 1));
                word.index = tmp[bsa_pkg::INDEX_W-1:0];
            end
        end
        else if (pick < 95)
        begin
            // noise on every field, any kind code
            tmp = $urandom_range(0, 3);
            word.kind = tmp[bsa_pkg::KIND_W-1:0];
        end
        else
        begin
            // read just past the image
            word.kind = $urandom_range(0, 1) ? bsa_pkg::OP_READ_CLR : bsa_pkg::OP_READ;
            tmp = w * h + int'($urandom_range(0, 40));
            word.index = tmp[bsa_pkg::INDEX_W-1:0];
        end
        return word;
    endfunction

    // offer one word after a random gap and wait until it is taken
    task automatic send_word(input splat_word_t word);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind <= word.kind;
        pos_x <= word.pos_x;
        pos_y <= word.pos_y;
        splat_value <= word.value;
        pixel_index <= word.index;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_word(word);
    endtask

    // wait for every read word, then let trailing splats finish
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bsa_pkg::CFG_INDEX_W-1:0] index, input int value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value[bsa_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == bsa_pkg::REG_IMAGE_WIDTH)
            image_width = int'(value[bsa_pkg::CFG_W-1:0]);
        else if (index == bsa_pkg::REG_IMAGE_HEIGHT)
            image_height = int'(value[bsa_pkg::CFG_W-1:0]);
    endtask

    function automatic void check_read_word();
        read_word_t want;
        if (expected_reads.size() == 0)
        begin
            $error("unexpected read word: pixel_sum %0h index_valid %0b",
                   pixel_sum, index_valid);
            error_count++;
            return;
        end
        want = expected_reads.pop_front();
        if (pixel_sum !== want.sum)
        begin
            $error("pixel_sum mismatch: expected %0h, actual %0h", want.sum, pixel_sum);
            error_count++;
        end
        if (index_valid !== want.valid)
        begin
            $error("index_valid mismatch: expected %0b, actual %0b", want.valid, index_valid);
            error_count++;
        end
    endfunction

    // result side: check each popped word, then stall a random number of cycles
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            check_read_word();
            if ($urandom_range(0, 39) == 0)
                recv_steady = !recv_steady;
            recv_wait = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
        end
        else if (recv_wait > 0)
            recv_wait--;
        pop <= (recv_wait == 0);
    end

    // full-size image: corners, position and value extremes, every kind
    task automatic test_reset_defaults();
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 0));
        send_word(make_word(bsa_pkg::OP_SPLAT, pixel_centre(0), pixel_centre(0),
                            24'hFFFFFF, 0));
        // three corners off the top-left edge
        send_word(make_word(bsa_pkg::OP_SPLAT, 0, 0, 24'h123456, 0));
        // straddling the bottom-right edge
        send_word(make_word(bsa_pkg::OP_SPLAT, pixel_centre(255) + 64,
                            pixel_centre(255) + 64, 24'hABCDEF, 0));
        send_word(make_word(bsa_pkg::OP_SPLAT, 20'h7FFFF, 20'h7FFFF, 24'hFFFFFF, 16'hFFFF));
        send_word(make_word(bsa_pkg::OP_SPLAT, 20'h80000, 20'h80000, 24'hFFFFFF, 0));
        send_word(make_word(bsa_pkg::OP_SPLAT, 20'h7FFFF, pixel_centre(3), 24'hFFFFFF, 0));
        send_word(make_word(bsa_pkg::OP_SPLAT, pixel_centre(1) + 77, pixel_centre(1) + 200,
                            0, 0));
        send_word(make_word(bsa_pkg::OP_SPLAT, pixel_centre(1) + 77, pixel_centre(1) + 200,
                            24'h00FF00, 0));
        send_word(make_word(KIND_IGNORED, pixel_centre(0), pixel_centre(0), 24'hFFFFFF, 0));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 0));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 257));
        send_word(make_word(bsa_pkg::OP_READ_CLR, 0, 0, 0, 258));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 258));
        send_word(make_word(bsa_pkg::OP_READ_CLR, 0, 0, 0, 16'hFFFF));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 16'hFFFF));
        send_word(make_word(bsa_pkg::OP_READ_CLR, 0, 0, 0, 0));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 0));
    endtask

    // small image: index bound and off-image corners
    task automatic test_index_bounds();
        wait_idle();
        write_reg(bsa_pkg::REG_IMAGE_WIDTH, 4);
        write_reg(bsa_pkg::REG_IMAGE_HEIGHT, 3);
        send_word(make_word(bsa_pkg::OP_SPLAT, pixel_centre(3) + 100, pixel_centre(2) + 30,
                            24'hFFFFFF, 0));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 11));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 12));
        send_word(make_word(bsa_pkg::OP_READ_CLR, 0, 0, 0, 12));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 16'hFFFF));
        send_word(make_word(bsa_pkg::OP_READ_CLR, 0, 0, 0, 11));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, 11));
    endtask

    // random traffic under a series of image sizes, extremes first
    task automatic test_image_sizes();
        int widths [12];
        int heights [12];
        widths = '{1, 256, 0, 511, 3, 256, 17, 300, 0, 0, 0, 0};
        heights = '{1, 256, 9, 5, 0, 1, 17, 511, 0, 0, 0, 0};
        for (int phase = 8; phase < 12; phase++)
        begin
            widths[phase] = (phase % 2) ? $urandom_range(1, 256) : $urandom_range(1, 16);
            heights[phase] = (phase % 2) ? $urandom_range(1, 256) : $urandom_range(1, 16);
        end
        for (int phase = 0; phase < 12; phase++)
        begin
            wait_idle();
            write_reg(bsa_pkg::REG_IMAGE_WIDTH, widths[phase]);
            write_reg(bsa_pkg::REG_IMAGE_HEIGHT, heights[phase]);
            // undecoded indexes must leave the sizes alone
            if (phase % 3 == 0)
            begin
                write_reg(REG_SPARE_A, $urandom_range(0, 511));
                write_reg(REG_SPARE_B, 511);
            end
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_word());
        end
    endtask

    // pile full-weight splats on one pixel until its sum saturates
    task automatic test_saturation();
        int index;
        wait_idle();
        write_reg(bsa_pkg::REG_IMAGE_WIDTH, 256);
        write_reg(bsa_pkg::REG_IMAGE_HEIGHT, 256);
        index = 20 * 256 + 10;
        for (int n = 0; n < SAT_WORDS; n++)
        begin
            if (n % 32 == 31)
                send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, index));
            else if (n % 16 == 7)
                send_word(random_word());
            else
                send_word(make_word(bsa_pkg::OP_SPLAT, pixel_centre(10), pixel_centre(20),
                                    24'hFFFFFF, 0));
        end
        send_word(make_word(bsa_pkg::OP_READ_CLR, 0, 0, 0, index));
        send_word(make_word(bsa_pkg::OP_READ, 0, 0, 0, index));
    endtask

    initial
    begin
        for (int i = 0; i < STORE_WORDS; i++)
            pixel_mirror[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_index_bounds();
        test_image_sizes();
        test_saturation();
        wait_idle();
        if (error_count == 0)
            $display("bilinear_splat_accumulator regression: pass");
        else
            $display("bilinear_splat_accumulator regression: fail");
        $finish;
    end

endmodule
